// ----- hdl/tvsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tvsp_pkg: shared types and constants of the tagged value stream parser
// Holds the entry phase, status and type codes, the result record and the
// helper functions for value sizes and sign extension.
// ----------------------------------------------------------------------------
package tvsp_pkg;

	// Phase of the entry being parsed.
	typedef enum logic [2:0] {
		PH_KEY    = 3'd0,
		PH_TYPE   = 3'd1,
		PH_NUM    = 3'd2,
		PH_SLEN   = 3'd3,
		PH_SBYTES = 3'd4,
		PH_BAD    = 3'd5
	} phase_t;

	// Status code carried by each result.
	typedef enum logic [2:0] {
		ST_NUM     = 3'd0,
		ST_SBYTE   = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_CUT     = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	// Type codes of an entry.
	localparam logic [2:0] TY_NONE  = 3'd0;
	localparam logic [2:0] TY_INT8  = 3'd1;
	localparam logic [2:0] TY_INT16 = 3'd2;
	localparam logic [2:0] TY_INT32 = 3'd3;
	localparam logic [2:0] TY_INT64 = 3'd4;
	localparam logic [2:0] TY_FX16  = 3'd5;
	localparam logic [2:0] TY_FX32  = 3'd6;
	localparam logic [2:0] TY_STR   = 3'd7;

	// Bytes in the key and in a string length field.
	localparam logic [3:0] KEY_BYTES  = 4'd4;
	localparam logic [3:0] SLEN_BYTES = 4'd2;

	// One result record.
	typedef struct packed {
		logic [31:0]        entry_key;
		logic [2:0]         type_code;
		logic signed [63:0] number_value;
		logic [7:0]         string_byte;
		logic               last_of_string;
		status_t            status;
	} result_t;

	// Number of value bytes for a numeric type.
	function automatic logic [3:0] value_size(input logic [2:0] t);
		logic [3:0] n;
		unique case (t)
			TY_INT8:  n = 4'd1;
			TY_INT16: n = 4'd2;
			TY_INT32: n = 4'd4;
			TY_INT64: n = 4'd8;
			TY_FX16:  n = 4'd4;
			TY_FX32:  n = 4'd8;
			default:  n = 4'd0;
		endcase
		return n;
	endfunction

	// Sign-extends the collected value word from the size of its type.
	function automatic logic [63:0] sign_extend(input logic [2:0] t, input logic [63:0] v);
		logic [63:0] r;
		unique case (t)
			TY_INT8:           r = {{56{v[7]}}, v[7:0]};
			TY_INT16:          r = {{48{v[15]}}, v[15:0]};
			TY_INT32, TY_FX16: r = {{32{v[31]}}, v[31:0]};
			default:           r = v;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/tvsp_core.sv -----
// ----------------------------------------------------------------------------
// tvsp_core: entry parser state and per-byte decode
// Holds the parser state and works out, for the byte in the input register,
// the next state and the result (if any) in one short combinational pass.
// ----------------------------------------------------------------------------
module tvsp_core
	import tvsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic [7:0] data_byte,
	input  logic    end_of_message,
	output logic    res_valid,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [2:0]  type_q, type_d;
	logic [15:0] remain_q, remain_d;
	logic        skip_q, skip_d;
	logic [31:0] key_q, key_d;
	logic [63:0] value_q, value_d;

	logic [3:0]  count_inc;
	logic [31:0] key_shifted;
	logic [63:0] value_shifted;
	logic [3:0]  need;
	logic [15:0] remain_dec;
	logic        entry_done;

	assign count_inc     = count_q + 4'd1;
	assign key_shifted   = {key_q[23:0], data_byte};
	assign value_shifted = {value_q[55:0], data_byte};
	assign need          = value_size(type_q);
	assign remain_dec    = remain_q - 16'd1;

	// Decode of one byte: next state and result.
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		type_d     = type_q;
		remain_d   = remain_q;
		skip_d     = skip_q;
		key_d      = key_q;
		value_d    = value_q;
		entry_done = 1'b0;
		res_valid  = 1'b0;
		res.entry_key      = key_q;
		res.type_code      = type_q;
		res.number_value   = '0;
		res.string_byte    = '0;
		res.last_of_string = 1'b0;
		res.status         = ST_NUM;

		if (skip_q) begin
			// Rest of a message after an unknown type is ignored.
		end else begin
			unique case (phase_q)
				PH_KEY: begin
					key_d   = key_shifted;
					count_d = count_inc;
					if (count_inc >= KEY_BYTES) begin
						count_d = '0;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					if (data_byte >= 8'd1 && data_byte <= 8'd7) begin
						type_d  = data_byte[2:0];
						phase_d = (data_byte[2:0] == TY_STR) ? PH_SLEN : PH_NUM;
					end else begin
						type_d  = TY_NONE;
						phase_d = PH_BAD;
					end
					count_d = '0;
					value_d = '0;
				end
				PH_NUM: begin
					value_d = value_shifted;
					count_d = count_inc;
					if (need == 4'd0 || count_inc >= need) begin
						res_valid        = 1'b1;
						res.number_value = sign_extend(type_q, value_shifted);
						res.status       = ST_NUM;
						entry_done       = 1'b1;
					end else if (end_of_message) begin
						res_valid  = 1'b1;
						res.status = ST_CUT;
					end
				end
				PH_SLEN: begin
					value_d = value_shifted;
					count_d = count_inc;
					if (count_inc >= SLEN_BYTES) begin
						remain_d = value_shifted[15:0];
						count_d  = '0;
						if (value_shifted[15:0] == 16'd0) begin
							res_valid          = 1'b1;
							res.last_of_string = 1'b1;
							res.status         = ST_EMPTY;
							entry_done         = 1'b1;
						end else if (end_of_message) begin
							res_valid  = 1'b1;
							res.status = ST_CUT;
						end else begin
							phase_d = PH_SBYTES;
						end
					end else if (end_of_message) begin
						res_valid  = 1'b1;
						res.status = ST_CUT;
					end
				end
				PH_SBYTES: begin
					remain_d = remain_dec;
					if (remain_dec == 16'd0) begin
						res_valid          = 1'b1;
						res.string_byte    = data_byte;
						res.last_of_string = 1'b1;
						res.status         = ST_SBYTE;
						entry_done         = 1'b1;
					end else if (end_of_message) begin
						res_valid  = 1'b1;
						res.status = ST_CUT;
					end else begin
						res_valid       = 1'b1;
						res.string_byte = data_byte;
						res.status      = ST_SBYTE;
					end
				end
				default: begin
					// Unknown type: report it on the sixth byte, then skip.
					res_valid  = 1'b1;
					res.status = ST_UNKNOWN;
					entry_done = 1'b1;
					skip_d     = !end_of_message;
				end
			endcase
		end

		// Finished entries and message ends return to key collection.
		if (entry_done || end_of_message) begin
			phase_d  = PH_KEY;
			count_d  = '0;
			type_d   = TY_NONE;
			remain_d = '0;
			key_d    = '0;
			value_d  = '0;
		end
		if (end_of_message) begin
			skip_d = 1'b0;
		end
		if (!step) begin
			res_valid = 1'b0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_KEY;
			count_q  <= '0;
			type_q   <= TY_NONE;
			remain_q <= '0;
			skip_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			type_q   <= type_d;
			remain_q <= remain_d;
			skip_q   <= skip_d;
		end
	end

	// Key and value shift registers.
	always_ff @(posedge clk) begin
		if (step) begin
			key_q   <= key_d;
			value_q <= value_d;
		end
	end

endmodule

// ----- hdl/tvsp_out_reg.sv -----
// ----------------------------------------------------------------------------
// tvsp_out_reg: result register
// Holds one result until the receiver takes it and tells the parser when
// it may advance.
// ----------------------------------------------------------------------------
module tvsp_out_reg
	import tvsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// The slot is free when empty or when its result leaves this cycle.
	assign advance   = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ----- hdl/tagged_value_stream_parser.sv -----
// ----------------------------------------------------------------------------
// tagged_value_stream_parser: type-length-value message parser
// Splits a byte stream of keyed, typed entries into numeric results and
// streamed string bytes.
// ----------------------------------------------------------------------------
// Usage:
// Message bytes enter on the input channel (in_valid, in_stall, data_byte,
// end_of_message), one byte per transfer, end_of_message high on the last
// byte of each message. Results leave on the output channel (out_valid,
// out_stall and the result fields): one transfer per numeric entry, per
// string byte, per empty string, per entry cut off in its length or
// value and per unknown type. A byte passes an input register and one
// decode step into the result register, where its result is shown and
// from which it can leave.
// The block takes one byte per cycle while the receiver does not stall;
// its rate is set by the combinational decode between the input and
// result registers. Bytes that cause no result (key, type, length and
// numeric body bytes) still pass through that decode step.
// When the receiver stalls, the result holds and the input stalls once
// the input register is also full; nothing is lost.
// Reset clears both valid flags and returns the parser to awaiting a key.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser
	import tvsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_message,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        entry_key,
	output logic [2:0]         type_code,
	output logic signed [63:0] number_value,
	output logic [7:0]         string_byte,
	output logic               last_of_string,
	output logic [2:0]         status
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eom_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// The input register waits only while its byte cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
	end

	// Parser state and decode.
	tvsp_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (data_s1),
		.end_of_message (eom_s1),
		.res_valid      (res_valid),
		.res            (res)
	);

	// Result register.
	tvsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign entry_key      = out_res.entry_key;
	assign type_code      = out_res.type_code;
	assign number_value   = out_res.number_value;
	assign string_byte    = out_res.string_byte;
	assign last_of_string = out_res.last_of_string;
	assign status         = out_res.status;

endmodule
